@@ rtl/cmc_pkg.sv @@
package cmc_pkg;

    // Block configuration
    localparam int WINDOW_LEN  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int TANH_DEPTH  = 1024;

    // Arithmetic widths
    localparam int TAP_W     = 16;
    localparam int TAPS_W    = 3 * TAP_W;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = TAP_W + SAMPLE_BITS;
    localparam int SUM_W     = (PROD_W + 2 > 29) ? PROD_W + 2 : 29;
    localparam int IDX_W     = $clog2(WINDOW_LEN);
    localparam int PEAK_W    = 4;
    localparam int TANH_AW   = $clog2(TANH_DEPTH);
    localparam int SAT_SHIFT = 27;                    // |sum| of 8.0 with 24 fraction bits
    localparam int IDX_SHIFT = SAT_SHIFT - TANH_AW;
    localparam int POOL_W    = 16;
    localparam int TANH_ONE  = 16384;
    localparam int WT_W      = 16;
    localparam int LOGIT_W   = POOL_W + WT_W + 2;
    localparam int ONE_SHIFT = 14;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int LVL_W   = $clog2(Q_DEPTH + 1);

    // Ports
    localparam int S_DATA_W   = 16;
    localparam int M_FIELDS_W = 1 + 2 * POOL_W + 2 * PEAK_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_SEL_W  = 3;
    localparam int REG_SEL_LSB = 3;

    // Register map
    typedef enum logic [REG_SEL_W-1:0] {
        REG_FILTER_A_TAPS,
        REG_BIAS_A,
        REG_FILTER_B_TAPS,
        REG_BIAS_B,
        REG_READOUT_WEIGHT_A,
        REG_READOUT_WEIGHT_B,
        REG_READOUT_OFFSET
    } reg_sel_t;

    typedef struct packed {
        logic [TAPS_W-1:0]       taps_a;
        logic signed [TAP_W-1:0] bias_a;
        logic [TAPS_W-1:0]       taps_b;
        logic signed [TAP_W-1:0] bias_b;
        logic signed [WT_W-1:0]  weight_a;
        logic signed [WT_W-1:0]  weight_b;
        logic signed [WT_W-1:0]  offset;
    } cfg_t;

    // One finished window: per-channel maximum and its first position
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_a;
        logic [IDX_W-1:0]        pos_a;
        logic signed [SUM_W-1:0] sum_b;
        logic [IDX_W-1:0]        pos_b;
    } peak_t;

    typedef logic [POOL_W-1:0] tanh_rom_t [TANH_DEPTH];

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint EXP_M1_Q30 = 64'sd395007542;

    // Quotient of a nonnegative value below 2^48 by a positive one, by shift and subtract
    function automatic longint shift_sub_div(longint a, longint b);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int j = 47; j >= 0; j--) begin
            r = (r <<< 1) | ((a >>> j) & 64'sd1);
            q = q <<< 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // tanh(8*i/TANH_DEPTH) in Q1.14 via exp(-2z) in Q30
    function automatic tanh_rom_t build_tanh();
        tanh_rom_t rom;
        longint t16;
        longint n;
        longint f;
        longint term;
        longint e;
        longint num;
        longint den;
        for (int i = 0; i < TANH_DEPTH; i++) begin
            t16  = 16 * longint'(i);
            n    = t16 / TANH_DEPTH;
            f    = ((t16 % TANH_DEPTH) <<< 30) / TANH_DEPTH;
            term = Q30_ONE;
            e    = Q30_ONE;
            for (int k = 1; k <= 20; k++) begin
                term = (term * f) >>> 30;
                term = shift_sub_div(term, longint'(k));
                if ((k % 2) == 1) begin
                    e = e - term;
                end else begin
                    e = e + term;
                end
            end
            for (longint m = 0; m < n; m++) begin
                e = (e * EXP_M1_Q30) >>> 30;
            end
            if (e < 0) begin
                e = 0;
            end
            num    = (Q30_ONE - e) * 2 * TANH_ONE + (Q30_ONE + e);
            den    = 2 * (Q30_ONE + e);
            rom[i] = POOL_W'(shift_sub_div(num, den));
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh();

endpackage

@@ rtl/cmc_front.sv @@
module cmc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cmc_pkg::S_DATA_W-1:0]       s_tdata,   // [15:0] sample
    input  cmc_pkg::cfg_t                      cfg,
    input  logic [cmc_pkg::LVL_W-1:0]          q_level,
    output logic                               push,
    output cmc_pkg::peak_t                     push_data
);

    localparam logic signed [cmc_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(cmc_pkg::SUM_W-1){1'b0}}};

    logic                                   in_fire;
    logic signed [cmc_pkg::SAMPLE_BITS-1:0] x;
    logic signed [cmc_pkg::TAP_W-1:0]       tap_a [3];
    logic signed [cmc_pkg::TAP_W-1:0]       tap_b [3];

    logic signed [cmc_pkg::SAMPLE_BITS-1:0] hist0_reg, hist1_reg;
    logic [cmc_pkg::IDX_W-1:0]              idx_reg, idx_next;

    // Stage 1: products
    logic                                   f1_valid_reg, f1_first_reg, f1_last_reg;
    logic [cmc_pkg::IDX_W-1:0]              f1_pos_reg;
    logic signed [cmc_pkg::PROD_W-1:0]      f1_prod_a_reg [3];
    logic signed [cmc_pkg::PROD_W-1:0]      f1_prod_b_reg [3];

    // Stage 2: filter sums
    logic                                   f2_valid_reg, f2_first_reg, f2_last_reg;
    logic [cmc_pkg::IDX_W-1:0]              f2_pos_reg;
    logic signed [cmc_pkg::SUM_W-1:0]       f2_sum_a_reg, f2_sum_b_reg;

    // Running maximum
    logic signed [cmc_pkg::SUM_W-1:0]       best_a_reg, best_a_next, best_b_reg, best_b_next;
    logic [cmc_pkg::IDX_W-1:0]              pos_a_reg, pos_a_next, pos_b_reg, pos_b_next;

    logic [cmc_pkg::LVL_W:0]                pending;

    assign x       = s_tdata[cmc_pkg::SAMPLE_BITS-1:0];
    assign in_fire = s_tvalid && s_tready;

    // Split tap words
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tap_a[k] = cfg.taps_a[k*cmc_pkg::TAP_W +: cmc_pkg::TAP_W];
            tap_b[k] = cfg.taps_b[k*cmc_pkg::TAP_W +: cmc_pkg::TAP_W];
        end
    end

    // Accept only while the queue can hold every window end still in flight
    assign pending = (cmc_pkg::LVL_W+1)'(q_level)
                   + (cmc_pkg::LVL_W+1)'(f1_valid_reg && f1_last_reg)
                   + (cmc_pkg::LVL_W+1)'(f2_valid_reg && f2_last_reg);
    assign s_tready = (pending < (cmc_pkg::LVL_W+1)'(cmc_pkg::Q_DEPTH));

    // Window position
    always_comb begin
        if (idx_reg == cmc_pkg::IDX_W'(cmc_pkg::WINDOW_LEN - 1)) begin
            idx_next = '0;
        end else begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (in_fire) begin
            idx_reg <= idx_next;
        end
    end

    // Shift sample history
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            hist0_reg <= hist1_reg;
            hist1_reg <= x;
        end
    end

    // Stage 1: six tap products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= in_fire && (idx_reg >= cmc_pkg::IDX_W'(2));
        end
    end

    always_ff @(posedge aclk) begin
        f1_first_reg     <= (idx_reg == cmc_pkg::IDX_W'(2));
        f1_last_reg      <= (idx_reg == cmc_pkg::IDX_W'(cmc_pkg::WINDOW_LEN - 1));
        f1_pos_reg       <= idx_reg - cmc_pkg::IDX_W'(2);
        f1_prod_a_reg[0] <= tap_a[0] * hist0_reg;
        f1_prod_a_reg[1] <= tap_a[1] * hist1_reg;
        f1_prod_a_reg[2] <= tap_a[2] * x;
        f1_prod_b_reg[0] <= tap_b[0] * hist0_reg;
        f1_prod_b_reg[1] <= tap_b[1] * hist1_reg;
        f1_prod_b_reg[2] <= tap_b[2] * x;
    end

    // Stage 2: add products and bias
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f2_first_reg <= f1_first_reg;
        f2_last_reg  <= f1_last_reg;
        f2_pos_reg   <= f1_pos_reg;
        f2_sum_a_reg <= cmc_pkg::SUM_W'(f1_prod_a_reg[0]) + cmc_pkg::SUM_W'(f1_prod_a_reg[1])
                      + cmc_pkg::SUM_W'(f1_prod_a_reg[2])
                      + (cmc_pkg::SUM_W'(cfg.bias_a) <<< cmc_pkg::FRAC_BITS);
        f2_sum_b_reg <= cmc_pkg::SUM_W'(f1_prod_b_reg[0]) + cmc_pkg::SUM_W'(f1_prod_b_reg[1])
                      + cmc_pkg::SUM_W'(f1_prod_b_reg[2])
                      + (cmc_pkg::SUM_W'(cfg.bias_b) <<< cmc_pkg::FRAC_BITS);
    end

    // Stage 3: update maximum; the first position always loads, ties keep the earlier one
    always_comb begin
        best_a_next = best_a_reg;
        pos_a_next  = pos_a_reg;
        best_b_next = best_b_reg;
        pos_b_next  = pos_b_reg;
        if (f2_first_reg || (f2_sum_a_reg > best_a_reg)) begin
            best_a_next = f2_sum_a_reg;
            pos_a_next  = f2_pos_reg;
        end
        if (f2_first_reg || (f2_sum_b_reg > best_b_reg)) begin
            best_b_next = f2_sum_b_reg;
            pos_b_next  = f2_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_a_reg <= SUM_MIN;
            best_b_reg <= SUM_MIN;
            pos_a_reg  <= '0;
            pos_b_reg  <= '0;
        end else if (f2_valid_reg) begin
            if (f2_last_reg) begin
                best_a_reg <= SUM_MIN;
                best_b_reg <= SUM_MIN;
                pos_a_reg  <= '0;
                pos_b_reg  <= '0;
            end else begin
                best_a_reg <= best_a_next;
                best_b_reg <= best_b_next;
                pos_a_reg  <= pos_a_next;
                pos_b_reg  <= pos_b_next;
            end
        end
    end

    // Hand the finished window to the queue
    assign push            = f2_valid_reg && f2_last_reg;
    assign push_data.sum_a = best_a_next;
    assign push_data.pos_a = pos_a_next;
    assign push_data.sum_b = best_b_next;
    assign push_data.pos_b = pos_b_next;

endmodule

@@ rtl/cmc_queue.sv @@
module cmc_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  cmc_pkg::peak_t            push_data,
    input  logic                      pop,
    output logic                      head_valid,
    output cmc_pkg::peak_t            head_data,
    output logic [cmc_pkg::LVL_W-1:0] level
);

    cmc_pkg::peak_t                  entry_reg [cmc_pkg::Q_DEPTH];
    logic [cmc_pkg::Q_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [cmc_pkg::LVL_W-1:0]       level_reg;

    function automatic logic [cmc_pkg::Q_AW-1:0] ptr_inc(input logic [cmc_pkg::Q_AW-1:0] p);
        if (p == cmc_pkg::Q_AW'(cmc_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Store entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    assign head_valid = (level_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign level      = level_reg;

endmodule

@@ rtl/cmc_back.sv @@
module cmc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  cmc_pkg::peak_t                head_data,
    output logic                          pop,
    input  cmc_pkg::cfg_t                 cfg,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] decision, [16:1] pooled_a, [32:17] pooled_b, [36:33] peak_pos_a,
    // [40:37] peak_pos_b, rest zero
    output logic [cmc_pkg::M_DATA_W-1:0]  m_tdata
);

    logic                                   en;
    logic signed [cmc_pkg::SUM_W-1:0]       head_sum [2];
    logic [cmc_pkg::IDX_W-1:0]              head_pos [2];
    logic [cmc_pkg::SUM_W-1:0]              mag [2];

    // B0: table index, saturation, sign
    logic                                   b0_valid_reg;
    logic                                   b0_neg_reg [2];
    logic                                   b0_sat_reg [2];
    logic [cmc_pkg::TANH_AW-1:0]            b0_idx_reg [2];
    logic [cmc_pkg::IDX_W-1:0]              b0_pos_reg [2];

    // B1: table read
    logic                                   b1_valid_reg;
    logic                                   b1_neg_reg [2];
    logic                                   b1_sat_reg [2];
    logic [cmc_pkg::POOL_W-1:0]             b1_rom_reg [2];
    logic [cmc_pkg::IDX_W-1:0]              b1_pos_reg [2];

    // B2: signed pooled values
    logic                                   b2_valid_reg;
    logic signed [cmc_pkg::POOL_W-1:0]      b2_pool_reg [2];
    logic [cmc_pkg::IDX_W-1:0]              b2_pos_reg [2];
    logic signed [cmc_pkg::POOL_W-1:0]      pool_mag [2];

    // B3: read-out products
    logic                                   b3_valid_reg;
    logic signed [cmc_pkg::POOL_W-1:0]      b3_pool_reg [2];
    logic [cmc_pkg::IDX_W-1:0]              b3_pos_reg [2];
    logic signed [cmc_pkg::POOL_W+cmc_pkg::WT_W-1:0] b3_prod_reg [2];

    // B4: output register
    logic                                   out_valid_reg;
    logic                                   out_decision_reg;
    logic signed [cmc_pkg::POOL_W-1:0]      out_pool_reg [2];
    logic [cmc_pkg::IDX_W-1:0]              out_pos_reg [2];
    logic signed [cmc_pkg::LOGIT_W-1:0]     logit;

    assign en  = !out_valid_reg || m_tready;
    assign pop = en && head_valid;

    assign head_sum[0] = head_data.sum_a;
    assign head_sum[1] = head_data.sum_b;
    assign head_pos[0] = head_data.pos_a;
    assign head_pos[1] = head_data.pos_b;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            mag[c] = head_sum[c][cmc_pkg::SUM_W-1] ? -head_sum[c] : head_sum[c];
            pool_mag[c] = b1_sat_reg[c] ? cmc_pkg::POOL_W'(cmc_pkg::TANH_ONE) : b1_rom_reg[c];
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            b0_valid_reg  <= head_valid;
            b1_valid_reg  <= b0_valid_reg;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    // Datapath; hold everything while the output is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                b0_neg_reg[c]  <= head_sum[c][cmc_pkg::SUM_W-1];
                b0_sat_reg[c]  <= (mag[c][cmc_pkg::SUM_W-1:cmc_pkg::SAT_SHIFT] != '0);
                b0_idx_reg[c]  <= mag[c][cmc_pkg::IDX_SHIFT +: cmc_pkg::TANH_AW];
                b0_pos_reg[c]  <= head_pos[c];

                b1_neg_reg[c]  <= b0_neg_reg[c];
                b1_sat_reg[c]  <= b0_sat_reg[c];
                b1_rom_reg[c]  <= cmc_pkg::TANH_ROM[b0_idx_reg[c]];
                b1_pos_reg[c]  <= b0_pos_reg[c];

                b2_pool_reg[c] <= b1_neg_reg[c] ? -pool_mag[c] : pool_mag[c];
                b2_pos_reg[c]  <= b1_pos_reg[c];

                b3_pool_reg[c] <= b2_pool_reg[c];
                b3_pos_reg[c]  <= b2_pos_reg[c];

                out_pool_reg[c] <= b3_pool_reg[c];
                out_pos_reg[c]  <= b3_pos_reg[c];
            end
            b3_prod_reg[0]   <= cfg.weight_a * b2_pool_reg[0];
            b3_prod_reg[1]   <= cfg.weight_b * b2_pool_reg[1];
            out_decision_reg <= !logit[cmc_pkg::LOGIT_W-1] && (logit != '0);
        end
    end

    // Logit with 26 fraction bits
    assign logit = cmc_pkg::LOGIT_W'(b3_prod_reg[0]) + cmc_pkg::LOGIT_W'(b3_prod_reg[1])
                 + (cmc_pkg::LOGIT_W'(cfg.offset) <<< cmc_pkg::ONE_SHIFT);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{cmc_pkg::M_PAD_W{1'b0}},
                       cmc_pkg::PEAK_W'(out_pos_reg[1]),
                       cmc_pkg::PEAK_W'(out_pos_reg[0]),
                       out_pool_reg[1],
                       out_pool_reg[0],
                       out_decision_reg};

endmodule

@@ rtl/two_channel_conv_maxpool_classifier_top.sv @@
// Throughput: one sample per cycle, sustained across windows while the queue has room.
// Path: a window's result passes 3 front stages for products, sums and the running maximum,
// then the queue, then 5 back stages for the tanh table read, sign, read-out multiply and
// logit compare. A 4-entry queue decouples them.
// Reset: aresetn is synchronous, active low; it clears all control state and the
// configuration registers. No memory clearing pass; the block is ready the cycle after reset.
module two_channel_conv_maxpool_classifier_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cmc_pkg::S_DATA_W-1:0]     s_tdata,   // [15:0] sample
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] decision, [16:1] pooled_a, [32:17] pooled_b, [36:33] peak_pos_a,
    // [40:37] peak_pos_b, [47:41] zero
    output logic [cmc_pkg::M_DATA_W-1:0]     m_tdata,
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cmc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cmc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cmc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    cmc_pkg::cfg_t                  cfg_reg;
    cmc_pkg::reg_sel_t              reg_sel;
    logic                           cfg_write;

    logic                           push;
    cmc_pkg::peak_t                 push_data;
    logic                           pop;
    logic                           head_valid;
    cmc_pkg::peak_t                 head_data;
    logic [cmc_pkg::LVL_W-1:0]      q_level;

    assign pready    = 1'b1;
    assign reg_sel   = cmc_pkg::reg_sel_t'(paddr[cmc_pkg::REG_SEL_LSB +: cmc_pkg::REG_SEL_W]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            case (reg_sel)
                cmc_pkg::REG_FILTER_A_TAPS:    cfg_reg.taps_a   <= pwdata[cmc_pkg::TAPS_W-1:0];
                cmc_pkg::REG_BIAS_A:           cfg_reg.bias_a   <= pwdata[cmc_pkg::TAP_W-1:0];
                cmc_pkg::REG_FILTER_B_TAPS:    cfg_reg.taps_b   <= pwdata[cmc_pkg::TAPS_W-1:0];
                cmc_pkg::REG_BIAS_B:           cfg_reg.bias_b   <= pwdata[cmc_pkg::TAP_W-1:0];
                cmc_pkg::REG_READOUT_WEIGHT_A: cfg_reg.weight_a <= pwdata[cmc_pkg::WT_W-1:0];
                cmc_pkg::REG_READOUT_WEIGHT_B: cfg_reg.weight_b <= pwdata[cmc_pkg::WT_W-1:0];
                cmc_pkg::REG_READOUT_OFFSET:   cfg_reg.offset   <= pwdata[cmc_pkg::WT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_sel)
            cmc_pkg::REG_FILTER_A_TAPS:
                prdata = cmc_pkg::CFG_DATA_W'(cfg_reg.taps_a);
            cmc_pkg::REG_BIAS_A:
                prdata = cmc_pkg::CFG_DATA_W'($unsigned(cfg_reg.bias_a));
            cmc_pkg::REG_FILTER_B_TAPS:
                prdata = cmc_pkg::CFG_DATA_W'(cfg_reg.taps_b);
            cmc_pkg::REG_BIAS_B:
                prdata = cmc_pkg::CFG_DATA_W'($unsigned(cfg_reg.bias_b));
            cmc_pkg::REG_READOUT_WEIGHT_A:
                prdata = cmc_pkg::CFG_DATA_W'($unsigned(cfg_reg.weight_a));
            cmc_pkg::REG_READOUT_WEIGHT_B:
                prdata = cmc_pkg::CFG_DATA_W'($unsigned(cfg_reg.weight_b));
            cmc_pkg::REG_READOUT_OFFSET:
                prdata = cmc_pkg::CFG_DATA_W'($unsigned(cfg_reg.offset));
            default:
                prdata = '0;
        endcase
    end

    cmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .q_level   (q_level),
        .push      (push),
        .push_data (push_data)
    );

    cmc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .level      (q_level)
    );

    cmc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .cfg        (cfg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Queue never takes a window it has no room for
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (q_level < cmc_pkg::LVL_W'(cmc_pkg::Q_DEPTH)))
        else $error("window queue overflow");

    // Back end only pops a filled queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_level != '0))
        else $error("window queue underflow");

    // Full queue stops the input side
    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_level == cmc_pkg::LVL_W'(cmc_pkg::Q_DEPTH)) |-> !s_tready)
        else $error("input accepted with full queue");

endmodule

@@ verif/tb_two_channel_conv_maxpool_classifier_top.sv @@
`timescale 1ns / 1ps

module tb_two_channel_conv_maxpool_classifier_top;
    import cmc_pkg::*;

    localparam int DRAIN_CYCLES   = 20;
    localparam int STEPS_PER_UNIT = TANH_DEPTH / 16;
    localparam int NUM_REGS       = int'(REG_READOUT_OFFSET) + 1;
    localparam logic [REG_SEL_W-1:0] REG_UNMAPPED = '1;

    // One expected window result
    typedef struct {
        logic        decision;
        logic [15:0] pooled_a;
        logic [15:0] pooled_b;
        logic [3:0]  peak_a;
        logic [3:0]  peak_b;
    } window_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [CFG_DATA_W-1:0]   pwdata = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    two_channel_conv_maxpool_classifier_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Model copy of the registers and the window state
    logic [TAPS_W-1:0] reg_file [NUM_REGS];
    longint            tanh_tab [TANH_DEPTH];
    longint            hist_prev2, hist_prev1;
    int                win_pos;
    longint            peak_sum_a, peak_sum_b;
    int                peak_pos_a, peak_pos_b;

    window_result_t    pending_results [$];
    int                errors = 0;
    int                sender_idle_pct = 0;
    int                receiver_idle_pct = 0;

    // Fill tanh(8*i/DEPTH) in Q1.14 from exp(-2z) in Q30
    function automatic void fill_tanh_table();
        longint f, term, e, whole;
        for (int i = 0; i < TANH_DEPTH; i++) begin
            whole = i / STEPS_PER_UNIT;
            f     = (longint'(i % STEPS_PER_UNIT) <<< 30) / STEPS_PER_UNIT;
            term  = Q30_ONE;
            e     = Q30_ONE;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * f) >>> 30) / k;
                e    = (k % 2 == 1) ? e - term : e + term;
            end
            for (longint m = 0; m < whole; m++) begin
                e = (e * EXP_M1_Q30) >>> 30;
            end
            if (e < 0) begin
                e = 0;
            end
            tanh_tab[i] = ((Q30_ONE - e) * 2 * TANH_ONE + (Q30_ONE + e)) / (2 * (Q30_ONE + e));
        end
    endfunction

    function automatic longint tanh_of(longint s);
        longint mag, idx, v;
        mag = (s < 0) ? -s : s;
        idx = mag >>> IDX_SHIFT;
        v   = (idx >= TANH_DEPTH) ? TANH_ONE : tanh_tab[idx];
        return (s < 0) ? -v : v;
    endfunction

    function automatic longint conv_sum(logic [TAPS_W-1:0] taps, logic [15:0] bias, longint x);
        return longint'($signed(bias)) * 4096
             + longint'($signed(taps[15:0]))  * hist_prev2
             + longint'($signed(taps[31:16])) * hist_prev1
             + longint'($signed(taps[47:32])) * x;
    endfunction

    function automatic void clear_window();
        win_pos    = 0;
        peak_sum_a = -(64'sd1 <<< 39);
        peak_sum_b = -(64'sd1 <<< 39);
        peak_pos_a = 0;
        peak_pos_b = 0;
    endfunction

    // Advance the model by one accepted sample, queue a result at window end
    function automatic void conv_pool_predict(logic [15:0] raw);
        longint         x, sa, sb, pa, pb, logit;
        int             p;
        window_result_t r;
        x = longint'($signed(raw));
        if (win_pos >= 2) begin
            p  = win_pos - 2;
            sa = conv_sum(reg_file[REG_FILTER_A_TAPS], reg_file[REG_BIAS_A][15:0], x);
            sb = conv_sum(reg_file[REG_FILTER_B_TAPS], reg_file[REG_BIAS_B][15:0], x);
            if (p == 0 || sa > peak_sum_a) begin
                peak_sum_a = sa;
                peak_pos_a = p;
            end
            if (p == 0 || sb > peak_sum_b) begin
                peak_sum_b = sb;
                peak_pos_b = p;
            end
        end
        if (win_pos == WINDOW_LEN - 1) begin
            pa    = tanh_of(peak_sum_a);
            pb    = tanh_of(peak_sum_b);
            logit = longint'($signed(reg_file[REG_READOUT_WEIGHT_A][15:0])) * pa
                  + longint'($signed(reg_file[REG_READOUT_WEIGHT_B][15:0])) * pb
                  + longint'($signed(reg_file[REG_READOUT_OFFSET][15:0])) * TANH_ONE;
            r.decision = (logit > 0);
            r.pooled_a = pa[15:0];
            r.pooled_b = pb[15:0];
            r.peak_a   = 4'(peak_pos_a);
            r.peak_b   = 4'(peak_pos_b);
            pending_results.push_back(r);
            clear_window();
        end else begin
            win_pos++;
        end
        hist_prev2 = hist_prev1;
        hist_prev1 = x;
    endfunction

    function automatic int reg_width(int r);
        return (r == int'(REG_FILTER_A_TAPS) || r == int'(REG_FILTER_B_TAPS)) ? TAPS_W : TAP_W;
    endfunction

    function automatic logic [15:0] rand_signed(int mag);
        int v;
        v = int'($urandom_range(2 * mag)) - mag;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Score each result transfer and randomize backpressure
    always @(posedge aclk) begin : score_results
        window_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("decision", 16'(want.decision), 16'(m_tdata[0]));
                check_field("pooled_a", want.pooled_a, m_tdata[16:1]);
                check_field("pooled_b", want.pooled_b, m_tdata[32:17]);
                check_field("peak_pos_a", 16'(want.peak_a), 16'(m_tdata[36:33]));
                check_field("peak_pos_b", 16'(want.peak_b), 16'(m_tdata[40:37]));
                check_field("padding", 16'h0000, 16'(m_tdata[47:41]));
            end
        end
        m_tready <= (int'($urandom_range(99)) >= receiver_idle_pct);
    end

    // Send one sample, with a random gap ahead of it
    task automatic send_sample(logic [15:0] sample);
        if (int'($urandom_range(99)) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (int'($urandom_range(99)) < sender_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        conv_pool_predict(sample);
    endtask

    // Hold off the sender until every expected result has come
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [REG_SEL_W-1:0] sel, logic [63:0] wdata,
                              output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(sel) << REG_SEL_LSB;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a register with junk above its width, and track it in the model
    task automatic program_register(int r, logic [47:0] value);
        logic [63:0] data, unused;
        data = {$urandom(), $urandom()};
        for (int b = 0; b < reg_width(r); b++) begin
            data[b] = value[b];
        end
        apb_access(1'b1, REG_SEL_W'(r), data, unused);
        if (r < NUM_REGS) begin
            reg_file[r] = (reg_width(r) == TAPS_W) ? data[47:0] : {32'h0, data[15:0]};
        end
    endtask

    task automatic check_registers();
        logic [63:0] rd;
        for (int r = 0; r < NUM_REGS; r++) begin
            apb_access(1'b0, REG_SEL_W'(r), 64'h0, rd);
            for (int b = 0; b < reg_width(r); b++) begin
                if (rd[b] !== reg_file[r][b]) begin
                    $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                             $time, r, reg_file[r], rd);
                    errors++;
                    break;
                end
            end
        end
    endtask

    function automatic logic [47:0] make_taps(int mode, int scale);
        case (mode)
            0:       return 48'({$urandom(), $urandom()});
            1:       return {rand_signed(scale), rand_signed(scale), rand_signed(scale)};
            2:       return (($urandom_range(1) == 0) ? 48'h0 :
                             {rand_signed(scale), rand_signed(scale), rand_signed(scale)});
            default: return {pick_extreme(), pick_extreme(), pick_extreme()};
        endcase
    endfunction

    function automatic logic [15:0] make_coef(int mode, int scale);
        case (mode)
            0:       return 16'($urandom());
            1:       return rand_signed(scale);
            2:       return 16'h0000;
            default: return pick_extreme();
        endcase
    endfunction

    task automatic randomize_config();
        int mode, scale, rmode;
        mode  = $urandom_range(3);
        rmode = $urandom_range(3);
        scale = $urandom_range(256, 8192);
        program_register(REG_FILTER_A_TAPS, make_taps(mode, scale));
        program_register(REG_BIAS_A, 48'(rand_signed(scale)));
        program_register(REG_FILTER_B_TAPS, make_taps(mode, scale));
        program_register(REG_BIAS_B, 48'(make_coef(mode == 2 ? 1 : mode, scale)));
        program_register(REG_READOUT_WEIGHT_A, 48'(make_coef(rmode, 4096)));
        program_register(REG_READOUT_WEIGHT_B, 48'(make_coef(rmode, 4096)));
        program_register(REG_READOUT_OFFSET, 48'(make_coef(rmode, 4096)));
        check_registers();
    endtask

    // Reset values read back, and a window of extreme samples through zero filters
    task automatic test_reset_state();
        logic [15:0] edge_samples [WINDOW_LEN];
        edge_samples = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                         16'h7FFF, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'h0000,
                         16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF};
        sender_idle_pct   = 26;
        receiver_idle_pct = 79;
        check_registers();
        foreach (edge_samples[k]) send_sample(edge_samples[k]);
    endtask

    // Full-scale coefficients, saturated sums, and a write to an unmapped index
    task automatic test_extreme_config();
        logic [15:0] edge_samples [WINDOW_LEN];
        logic [63:0] unused;
        edge_samples = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
                         16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF};
        wait_results_drained();
        program_register(REG_FILTER_A_TAPS, 48'h8000_8000_8000);
        program_register(REG_BIAS_A, 48'h7FFF);
        program_register(REG_FILTER_B_TAPS, 48'h7FFF_0000_8000);
        program_register(REG_BIAS_B, 48'h8000);
        program_register(REG_READOUT_WEIGHT_A, 48'h7FFF);
        program_register(REG_READOUT_WEIGHT_B, 48'h8000);
        program_register(REG_READOUT_OFFSET, 48'h8000);
        apb_access(1'b1, REG_UNMAPPED, {$urandom(), $urandom()}, unused);
        check_registers();
        foreach (edge_samples[k]) send_sample(edge_samples[k]);
    endtask

    // Random windows under one idling pattern, reconfiguring every few windows
    task automatic test_random_windows(int n_windows, int send_pct, int recv_pct);
        int          smode;
        logic [15:0] held, s;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int w = 0; w < n_windows; w++) begin
            if (w % 6 == 0) begin
                wait_results_drained();
                randomize_config();
            end
            smode = $urandom_range(9);
            held  = 16'($urandom());
            for (int k = 0; k < WINDOW_LEN; k++) begin
                if (w == 1 && k == 7) begin
                    wait_results_drained();
                end
                if (smode < 4) begin
                    s = 16'($urandom());
                end else if (smode < 7) begin
                    s = rand_signed(2048);
                end else if (smode < 8) begin
                    s = held;
                end else begin
                    s = pick_extreme();
                end
                send_sample(s);
            end
        end
    endtask

    initial begin
        fill_tanh_table();
        for (int r = 0; r < NUM_REGS; r++) reg_file[r] = '0;
        hist_prev2 = 0;
        hist_prev1 = 0;
        clear_window();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_extreme_config();
        test_random_windows(36, 26, 79);
        test_random_windows(36, 79, 26);
        test_random_windows(36, 0, 0);

        wait_results_drained();
        if (errors == 0) begin
            $display("tb_two_channel_conv_maxpool_classifier_top: PASS");
        end else begin
            $display("tb_two_channel_conv_maxpool_classifier_top: FAIL");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #5000000;
        $display("tb_two_channel_conv_maxpool_classifier_top: FAIL");
        $finish;
    end

endmodule
